### rtl/fsts_pkg.sv
// Package for the fair-share task scheduler: operation codes, weight table,
// command and job types. Used by every module of the block; depends on nothing.
package fsts_pkg;

    localparam int DefNumTasks   = 16;
    localparam int DefRuntimeBits = 32;
    localparam int ModeW   = 3;
    localparam int IdW     = 4;
    localparam int LevelW  = 6;
    localparam int WeightW = 17;
    localparam int BusyW   = 7;
    localparam int FloorW  = 32;
    localparam int LevelCount = 40;

    localparam logic [WeightW-1:0] IdleWeight    = 17'd88761;
    localparam logic [WeightW-1:0] DefaultWeight = 17'd1024;
    localparam logic [WeightW-1:0] ClampLimit    = 17'd88761;
    localparam logic [BusyW-1:0]   BusyMax       = 7'd100;

    typedef enum logic [ModeW-1:0] {
        MODE_TICK    = 3'd0,
        MODE_CREATE  = 3'd1,
        MODE_DELETE  = 3'd2,
        MODE_SUSPEND = 3'd3,
        MODE_RESUME  = 3'd4,
        MODE_SETPRIO = 3'd5
    } mode_t;

    // One queued command word.
    typedef struct packed {
        logic [ModeW-1:0]   mode;
        logic [IdW-1:0]     task_id;
        logic [LevelW-1:0]  level;
        logic               intact;
        logic               level_ok;
    } cmd_t;

    // Weight for a nice level offset 0..39.
    function automatic logic [WeightW-1:0] weight_of(input logic [5:0] idx);
        logic [WeightW-1:0] w;
        begin
            case (idx)
                6'd0: w = 17'd88761;  6'd1: w = 17'd71755;  6'd2: w = 17'd56483;
                6'd3: w = 17'd46273;  6'd4: w = 17'd36291;  6'd5: w = 17'd29154;
                6'd6: w = 17'd23254;  6'd7: w = 17'd18705;  6'd8: w = 17'd14949;
                6'd9: w = 17'd11916;  6'd10: w = 17'd9548;  6'd11: w = 17'd7620;
                6'd12: w = 17'd6100;  6'd13: w = 17'd4904;  6'd14: w = 17'd3906;
                6'd15: w = 17'd3121;  6'd16: w = 17'd2501;  6'd17: w = 17'd1991;
                6'd18: w = 17'd1586;  6'd19: w = 17'd1277;  6'd20: w = 17'd1024;
                6'd21: w = 17'd820;   6'd22: w = 17'd655;   6'd23: w = 17'd526;
                6'd24: w = 17'd423;   6'd25: w = 17'd335;   6'd26: w = 17'd272;
                6'd27: w = 17'd215;   6'd28: w = 17'd172;   6'd29: w = 17'd137;
                6'd30: w = 17'd110;   6'd31: w = 17'd87;    6'd32: w = 17'd70;
                6'd33: w = 17'd56;    6'd34: w = 17'd45;    6'd35: w = 17'd36;
                6'd36: w = 17'd29;    6'd37: w = 17'd23;    6'd38: w = 17'd18;
                6'd39: w = 17'd15;
                default: w = 17'd15;
            endcase
            weight_of = w;
        end
    endfunction

endpackage

### rtl/fsts_front.sv
// Front end: accepts commands, checks the priority level and queues the word.
// Depends on fsts_pkg.
module fsts_front
    import fsts_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [ModeW-1:0]    mode,
    input  logic [IdW-1:0]      task_id,
    input  logic signed [LevelW-1:0] priority_req,
    input  logic                stack_intact,
    input  logic                back_idle,
    input  logic                pop,
    output logic                busy,
    output logic                q_valid,
    output cmd_t                q_word
);

    logic   full_reg;
    logic   full_next;
    cmd_t   word_reg;
    logic   take;

    // One entry queue; a new word is taken only when the back is idle too.
    assign busy = full_reg || !back_idle;
    assign take = start && !busy;

    always_comb
    begin
        full_next = full_reg;
        if (pop)
        begin
            full_next = 1'b0;
        end
        if (take)
        begin
            full_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    // Capture the command word; classify the level as inside -20..19 or not.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            word_reg.mode     <= mode;
            word_reg.task_id  <= task_id;
            word_reg.level    <= priority_req + 6'sd20;
            word_reg.intact   <= stack_intact;
            word_reg.level_ok <= (priority_req >= -6'sd20) && (priority_req <= 6'sd19);
        end
    end

    assign q_valid = full_reg;
    assign q_word  = word_reg;

endmodule

### rtl/fsts_back.sv
// Back end: slot table and the sequencer that scans slots for the least
// relative runtime. Depends on fsts_pkg.
module fsts_back
    import fsts_pkg::*;
#(
    parameter int NUM_TASKS    = DefNumTasks,
    parameter int RUNTIME_BITS = DefRuntimeBits
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                scheduler_enable,
    input  logic                q_valid,
    input  cmd_t                q_word,
    output logic                pop,
    output logic                idle,
    output logic                result_valid,
    output logic                status,
    output logic [IdW-1:0]      created_id,
    output logic [IdW-1:0]      current_id,
    output logic [IdW-1:0]      chosen_id,
    output logic [BusyW-1:0]    busy_percent,
    output logic [FloorW-1:0]   floor_runtime
);

    localparam int SlotW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int CntW  = $clog2(NUM_TASKS + 1);
    localparam logic [CntW-1:0] LastSlot = CntW'(NUM_TASKS - 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_EXEC, ST_SWOLD, ST_SCAN, ST_SWNEW, ST_TICKEND, ST_DONE
    } state_t;

    // Continuation after a scan.
    typedef enum logic [1:0] {
        AFT_SWITCH, AFT_TICK, AFT_CHOOSE
    } after_t;

    state_t                     state_reg;
    after_t                     after_reg;
    logic [NUM_TASKS-1:0]       used_reg;
    logic [NUM_TASKS-1:0]       susp_reg;
    logic [WeightW-1:0]         weight_reg [NUM_TASKS];
    logic [RUNTIME_BITS-1:0]    rt_reg [NUM_TASKS];
    logic [SlotW-1:0]           cur_reg;
    logic [SlotW-1:0]           chosen_reg;
    logic [RUNTIME_BITS-1:0]    min_reg;
    logic [BusyW-1:0]           busy_reg;
    logic [CntW-1:0]            scan_reg;
    logic [SlotW-1:0]           best_reg;
    logic [RUNTIME_BITS-1:0]    key_reg;
    logic                       found_reg;
    logic                       status_reg;
    logic [SlotW-1:0]           created_reg;
    logic                       tick_after_reg;
    cmd_t                       cmd_reg;
    logic                       rv_reg;

    logic [SlotW-1:0]           id_s;
    logic                       id_ok;
    logic [SlotW-1:0]           scan_s;
    logic [RUNTIME_BITS-1:0]    scan_key;
    logic                       scan_run;
    logic [SlotW-1:0]           free_idx;
    logic                       free_any;
    logic [RUNTIME_BITS-1:0]    resume_d;

    assign id_ok   = 32'(cmd_reg.task_id) < NUM_TASKS;
    assign id_s    = SlotW'(cmd_reg.task_id);
    assign scan_s  = scan_reg[SlotW-1:0];
    assign scan_key = rt_reg[scan_s] - min_reg;
    assign scan_run = used_reg[scan_s] && !susp_reg[scan_s];
    assign resume_d = rt_reg[id_s] - min_reg;

    // Lowest free slot, a priority encoder over the used bits.
    always_comb
    begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = NUM_TASKS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_idx = SlotW'(i);
                free_any = 1'b1;
            end
        end
    end

    assign pop  = (state_reg == ST_IDLE) && q_valid;
    assign idle = (state_reg == ST_IDLE);

    // Sequencer holding state, the slot table and the result word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            after_reg  <= AFT_TICK;
            used_reg   <= NUM_TASKS'(1);
            susp_reg   <= '0;
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                weight_reg[i] <= (i == 0) ? IdleWeight : DefaultWeight;
                rt_reg[i]     <= '0;
            end
            cur_reg    <= '0;
            chosen_reg <= '0;
            min_reg    <= '0;
            busy_reg   <= '0;
            scan_reg   <= '0;
            best_reg   <= '0;
            key_reg    <= '0;
            found_reg  <= 1'b0;
            status_reg <= 1'b0;
            created_reg <= '0;
            tick_after_reg <= 1'b0;
            cmd_reg    <= '0;
            rv_reg     <= 1'b0;
        end
        else
        begin
            rv_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg <= q_word;
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    status_reg  <= 1'b0;
                    created_reg <= '0;
                    tick_after_reg <= 1'b0;
                    state_reg   <= ST_DONE;
                    scan_reg    <= '0;
                    found_reg   <= 1'b0;
                    case (cmd_reg.mode)
                        MODE_TICK:
                        begin
                            if (scheduler_enable)
                            begin
                                rt_reg[cur_reg] <= rt_reg[cur_reg]
                                    + RUNTIME_BITS'(weight_reg[cur_reg]);
                                if (!cmd_reg.intact && cur_reg != '0)
                                begin
                                    used_reg[cur_reg] <= 1'b0;
                                    susp_reg[cur_reg] <= 1'b0;
                                    tick_after_reg <= 1'b1;
                                    state_reg <= ST_SWOLD;
                                end
                                else
                                begin
                                    after_reg <= AFT_TICK;
                                    state_reg <= ST_SCAN;
                                end
                            end
                        end
                        MODE_CREATE:
                        begin
                            if (free_any)
                            begin
                                used_reg[free_idx]   <= 1'b1;
                                susp_reg[free_idx]   <= 1'b0;
                                weight_reg[free_idx] <= DefaultWeight;
                                rt_reg[free_idx]     <= min_reg;
                                created_reg <= free_idx;
                            end
                            else
                            begin
                                status_reg <= 1'b1;
                            end
                        end
                        MODE_DELETE:
                        begin
                            if (!id_ok || id_s == '0 || !used_reg[id_s])
                            begin
                                status_reg <= 1'b1;
                            end
                            else
                            begin
                                used_reg[id_s] <= 1'b0;
                                susp_reg[id_s] <= 1'b0;
                                if (id_s == cur_reg)
                                begin
                                    state_reg <= ST_SWOLD;
                                end
                                else
                                begin
                                    after_reg <= AFT_CHOOSE;
                                    state_reg <= ST_SCAN;
                                end
                            end
                        end
                        MODE_SUSPEND:
                        begin
                            if (!id_ok || id_s == '0 || !used_reg[id_s])
                            begin
                                status_reg <= 1'b1;
                            end
                            else if (!susp_reg[id_s])
                            begin
                                susp_reg[id_s] <= 1'b1;
                                if (id_s == cur_reg)
                                begin
                                    state_reg <= ST_SWOLD;
                                end
                            end
                        end
                        MODE_RESUME:
                        begin
                            if (!id_ok || !used_reg[id_s])
                            begin
                                status_reg <= 1'b1;
                            end
                            else if (susp_reg[id_s])
                            begin
                                if (resume_d > RUNTIME_BITS'(ClampLimit))
                                begin
                                    rt_reg[id_s] <= min_reg;
                                end
                                susp_reg[id_s] <= 1'b0;
                            end
                        end
                        MODE_SETPRIO:
                        begin
                            if (!cmd_reg.level_ok)
                            begin
                                status_reg <= 1'b1;
                            end
                            else
                            begin
                                weight_reg[cur_reg] <= weight_of(cmd_reg.level);
                            end
                        end
                        default:
                        begin
                            status_reg <= 1'b1;
                        end
                    endcase
                end
                ST_SWOLD:
                begin
                    // The old task is charged half its weight before the scan.
                    rt_reg[cur_reg] <= rt_reg[cur_reg]
                        + RUNTIME_BITS'(weight_reg[cur_reg] >> 1);
                    after_reg <= AFT_SWITCH;
                    scan_reg  <= '0;
                    found_reg <= 1'b0;
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    // One slot a cycle; ties keep the lower index.
                    if (scan_run && (!found_reg || scan_key < key_reg))
                    begin
                        best_reg  <= scan_s;
                        key_reg   <= scan_key;
                        found_reg <= 1'b1;
                    end
                    if (scan_reg == LastSlot)
                    begin
                        case (after_reg)
                            AFT_SWITCH: state_reg <= ST_SWNEW;
                            AFT_TICK:   state_reg <= ST_TICKEND;
                            default:
                            begin
                                chosen_reg <= (scan_run && (!found_reg || scan_key < key_reg))
                                    ? scan_s : best_reg;
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                    scan_reg <= scan_reg + CntW'(1);
                end
                ST_SWNEW:
                begin
                    rt_reg[best_reg] <= rt_reg[best_reg]
                        - RUNTIME_BITS'(weight_reg[best_reg] >> 1);
                    min_reg    <= rt_reg[best_reg]
                        - RUNTIME_BITS'(weight_reg[best_reg] >> 1);
                    chosen_reg <= best_reg;
                    cur_reg    <= best_reg;
                    if (tick_after_reg)
                    begin
                        after_reg <= AFT_TICK;
                        scan_reg  <= '0;
                        found_reg <= 1'b0;
                        state_reg <= ST_SCAN;
                    end
                    else
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_TICKEND:
                begin
                    chosen_reg <= best_reg;
                    cur_reg    <= best_reg;
                    min_reg    <= rt_reg[best_reg];
                    if (best_reg == '0)
                    begin
                        if (busy_reg != '0)
                        begin
                            busy_reg <= busy_reg - BusyW'(1);
                        end
                    end
                    else if (busy_reg < BusyMax)
                    begin
                        busy_reg <= busy_reg + BusyW'(1);
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    rv_reg    <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid  = rv_reg;
    assign status        = status_reg;
    assign created_id    = IdW'(created_reg);
    assign current_id    = IdW'(cur_reg);
    assign chosen_id     = IdW'(chosen_reg);
    assign busy_percent  = busy_reg;
    assign floor_runtime = FloorW'(min_reg);

    // The idle slot never leaves the runnable set.
    a_idle_runnable: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg[0] && !susp_reg[0])
        else $error("idle slot lost");

    // The busy count never passes its ceiling.
    a_busy_cap: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg <= BusyMax)
        else $error("busy count overflow");

    // A result word is shown in the cycle after the sequencer's done state.
    a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE |=> rv_reg)
        else $error("missing result");

    // Whenever the sequencer is idle, the running task is a used slot.
    a_cur_used: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> used_reg[cur_reg])
        else $error("running task not used");

endmodule

### rtl/fair_share_task_scheduler_top.sv
// Top level of the fair-share task scheduler: front end, queue and back end.
// Depends on fsts_pkg, fsts_front and fsts_back.
//
// Usage: raise start with mode, task_id, priority_req and stack_intact while
// busy is low; the word is taken at that clock edge. Exactly one result word
// per command appears on status, created_id, current_id, chosen_id,
// busy_percent and floor_runtime for one cycle, marked by done.
// Every command passes the queue register and the exec and done states; an
// enabled tick adds a scan and a tick-end step, a delete of another task a
// scan, a switch away the old-task charge, a scan and the new-task credit,
// and a tick that deletes the running task that switch, a further scan and
// the tick-end step. The scan takes one slot per cycle. One command is in
// the back end at a time; busy stays high until its result has been shown.
// The receiver cannot stall: done is a one-cycle strobe. The user writes
// the scheduler_enable register through cfg_valid and cfg_ready (always
// ready) only while no command is in flight; the block does not enforce it.
// Reset clears the table to only the idle slot 0 in use and the enable to 0.
module fair_share_task_scheduler_top
    import fsts_pkg::*;
#(
    parameter int NUM_TASKS    = DefNumTasks,
    parameter int RUNTIME_BITS = DefRuntimeBits
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [ModeW-1:0]         mode,
    input  logic [IdW-1:0]           task_id,
    input  logic signed [LevelW-1:0] priority_req,
    input  logic                     stack_intact,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic                     cfg_data,
    output logic                     done,
    output logic                     status,
    output logic [IdW-1:0]           created_id,
    output logic [IdW-1:0]           current_id,
    output logic [IdW-1:0]           chosen_id,
    output logic [BusyW-1:0]         busy_percent,
    output logic [FloorW-1:0]        floor_runtime
);

    logic   enable_reg;
    logic   q_valid;
    cmd_t   q_word;
    logic   pop;
    logic   back_idle;
    logic   front_busy;

    // Enable register.
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            enable_reg <= cfg_data;
        end
    end

    // Busy also covers the cycle in which the result word is shown.
    assign busy = front_busy || done;

    fsts_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start && !done),
        .mode         (mode),
        .task_id      (task_id),
        .priority_req (priority_req),
        .stack_intact (stack_intact),
        .back_idle    (back_idle),
        .pop          (pop),
        .busy         (front_busy),
        .q_valid      (q_valid),
        .q_word       (q_word)
    );

    fsts_back #(
        .NUM_TASKS    (NUM_TASKS),
        .RUNTIME_BITS (RUNTIME_BITS)
    ) u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .scheduler_enable (enable_reg),
        .q_valid          (q_valid),
        .q_word           (q_word),
        .pop              (pop),
        .idle             (back_idle),
        .result_valid     (done),
        .status           (status),
        .created_id       (created_id),
        .current_id       (current_id),
        .chosen_id        (chosen_id),
        .busy_percent     (busy_percent),
        .floor_runtime    (floor_runtime)
    );

endmodule

### tb/fair_share_task_scheduler_top_test.sv
// Self-checking testbench for fair_share_task_scheduler_top: a clocked driver
// feeds command words and enable writes from a queue, and a monitor checks
// each result word against a built-in scheduler model. Depends on fsts_pkg.
module fair_share_task_scheduler_top_test;
    import fsts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NumSlots    = 16;
    localparam int SettleCyc   = 60;
    localparam logic StOk      = 1'b0;
    localparam logic StReject  = 1'b1;
    localparam logic [3:0] IdleSlot = 4'd0;

    // One pending stimulus entry: a command word or an enable write.
    typedef struct {
        bit         is_cfg;
        logic [2:0] mode;
        logic [3:0] id;
        logic [5:0] prio;
        logic       intact;
        logic       cfg_val;
    } sched_word_t;

    // One expected result word.
    typedef struct {
        logic        status;
        logic [3:0]  created;
        logic [3:0]  current;
        logic [3:0]  chosen;
        logic [6:0]  busy_pct;
        logic [31:0] floor_rt;
    } sched_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [ModeW-1:0] mode = '0;
    logic [IdW-1:0] task_id = '0;
    logic signed [LevelW-1:0] priority_req = '0;
    logic stack_intact = 1'b1;
    logic cfg_valid = 1'b0;
    logic cfg_data = 1'b0;
    logic busy, cfg_ready, done, status;
    logic [IdW-1:0] created_id, current_id, chosen_id;
    logic [BusyW-1:0] busy_percent;
    logic [FloorW-1:0] floor_runtime;

    sched_word_t   word_queue[$];
    sched_result_t expected_results[$];
    int  error_count = 0;
    int  idle_cycles = 0;
    int  gap_left = 0;
    int  accept_count = 0;
    bit  no_gap_stretch = 0;
    bit  drv_active = 0;

    // Model state of the scheduler.
    logic        m_enable;
    logic        m_used[NumSlots];
    logic        m_susp[NumSlots];
    logic [16:0] m_weight[NumSlots];
    logic [31:0] m_rt[NumSlots];
    logic [3:0]  m_current, m_chosen;
    logic [31:0] m_floor;
    logic [6:0]  m_busy;

    localparam logic [16:0] NiceWeight[40] = '{
        17'd88761, 17'd71755, 17'd56483, 17'd46273, 17'd36291, 17'd29154, 17'd23254,
        17'd18705, 17'd14949, 17'd11916, 17'd9548, 17'd7620, 17'd6100, 17'd4904,
        17'd3906, 17'd3121, 17'd2501, 17'd1991, 17'd1586, 17'd1277, 17'd1024,
        17'd820, 17'd655, 17'd526, 17'd423, 17'd335, 17'd272, 17'd215, 17'd172,
        17'd137, 17'd110, 17'd87, 17'd70, 17'd56, 17'd45, 17'd36, 17'd29, 17'd23,
        17'd18, 17'd15
    };

    fair_share_task_scheduler_top u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .task_id(task_id), .priority_req(priority_req), .stack_intact(stack_intact),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .done(done), .status(status), .created_id(created_id),
        .current_id(current_id), .chosen_id(chosen_id),
        .busy_percent(busy_percent), .floor_runtime(floor_runtime)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Reset the model to the power-up table.
    function automatic void model_reset();
        m_enable = 1'b0;
        for (int i = 0; i < NumSlots; i++)
        begin
            m_used[i] = 1'b0;
            m_susp[i] = 1'b0;
            m_weight[i] = DefaultWeight;
            m_rt[i] = '0;
        end
        m_used[0] = 1'b1;
        m_weight[0] = IdleWeight;
        m_current = IdleSlot;
        m_chosen = IdleSlot;
        m_floor = '0;
        m_busy = '0;
    endfunction

    // Runnable slot with the least runtime above the floor, lowest index on ties.
    function automatic logic [3:0] least_runnable();
        logic [3:0]  best;
        logic [31:0] best_key, key;
        bit          found;
        best = IdleSlot;
        best_key = '0;
        found = 0;
        for (int i = 0; i < NumSlots; i++)
        begin
            if (m_used[i] && !m_susp[i])
            begin
                key = m_rt[i] - m_floor;
                if (!found || key < best_key)
                begin
                    best = i[3:0];
                    best_key = key;
                    found = 1;
                end
            end
        end
        return best;
    endfunction

    // Leave the running task: charge it half a weight, credit the next one.
    function automatic void switch_task();
        logic [3:0] nxt;
        m_rt[m_current] = m_rt[m_current] + 32'(m_weight[m_current] >> 1);
        nxt = least_runnable();
        m_rt[nxt] = m_rt[nxt] - 32'(m_weight[nxt] >> 1);
        m_floor = m_rt[nxt];
        m_chosen = nxt;
        m_current = nxt;
    endfunction

    // Apply one command word to the model and return the result word.
    function automatic sched_result_t schedule_command(sched_word_t w);
        sched_result_t r;
        logic [3:0] nxt;
        int lvl;
        r.status = StOk;
        r.created = '0;
        lvl = int'($signed(w.prio));
        case (w.mode)
            MODE_TICK:
                if (m_enable)
                begin
                    m_rt[m_current] = m_rt[m_current] + 32'(m_weight[m_current]);
                    if (!w.intact && m_current != IdleSlot)
                    begin
                        m_used[m_current] = 1'b0;
                        m_susp[m_current] = 1'b0;
                        switch_task();
                    end
                    nxt = least_runnable();
                    m_chosen = nxt;
                    m_floor = m_rt[nxt];
                    if (nxt == IdleSlot)
                    begin
                        if (m_busy > 0)
                            m_busy = m_busy - 7'd1;
                    end
                    else if (m_busy < BusyMax)
                        m_busy = m_busy + 7'd1;
                    m_current = nxt;
                end
            MODE_CREATE:
            begin
                r.status = StReject;
                for (int i = 0; i < NumSlots; i++)
                begin
                    if (r.status == StReject && !m_used[i])
                    begin
                        m_used[i] = 1'b1;
                        m_susp[i] = 1'b0;
                        m_weight[i] = DefaultWeight;
                        m_rt[i] = m_floor;
                        r.created = i[3:0];
                        r.status = StOk;
                    end
                end
            end
            MODE_DELETE:
                if (w.id == IdleSlot || !m_used[w.id])
                    r.status = StReject;
                else
                begin
                    m_used[w.id] = 1'b0;
                    m_susp[w.id] = 1'b0;
                    if (w.id == m_current)
                        switch_task();
                    else
                        m_chosen = least_runnable();
                end
            MODE_SUSPEND:
                if (w.id == IdleSlot || !m_used[w.id])
                    r.status = StReject;
                else if (!m_susp[w.id])
                begin
                    m_susp[w.id] = 1'b1;
                    if (w.id == m_current)
                        switch_task();
                end
            MODE_RESUME:
                if (!m_used[w.id])
                    r.status = StReject;
                else if (m_susp[w.id])
                begin
                    if (m_rt[w.id] - m_floor > 32'(ClampLimit))
                        m_rt[w.id] = m_floor;
                    m_susp[w.id] = 1'b0;
                end
            MODE_SETPRIO:
                if (lvl < -20 || lvl > 19)
                    r.status = StReject;
                else
                    m_weight[m_current] = NiceWeight[lvl + 20];
            default:
                r.status = StReject;
        endcase
        r.current = m_current;
        r.chosen = m_chosen;
        r.busy_pct = m_busy;
        r.floor_rt = m_floor;
        return r;
    endfunction

    function automatic sched_word_t make_cmd(logic [2:0] md, logic [3:0] id,
                                             logic [5:0] pr, logic intact);
        sched_word_t w;
        w.is_cfg = 0;
        w.mode = md;
        w.id = id;
        w.prio = pr;
        w.intact = intact;
        w.cfg_val = 1'b0;
        return w;
    endfunction

    function automatic sched_word_t make_cfg(logic v);
        sched_word_t w;
        w = make_cmd(MODE_TICK, '0, '0, 1'b1);
        w.is_cfg = 1;
        w.cfg_val = v;
        return w;
    endfunction

    // Random command word, weighted toward ticks and valid levels.
    function automatic sched_word_t random_cmd();
        int r;
        logic [2:0] md;
        logic [5:0] pr;
        r = $urandom_range(0, 99);
        if (r < 38) md = MODE_TICK;
        else if (r < 53) md = MODE_CREATE;
        else if (r < 65) md = MODE_DELETE;
        else if (r < 76) md = MODE_SUSPEND;
        else if (r < 87) md = MODE_RESUME;
        else if (r < 97) md = MODE_SETPRIO;
        else md = 3'($urandom_range(6, 7));
        if ($urandom_range(0, 99) < 85)
            pr = 6'($signed($urandom_range(0, 39)) - 20);
        else
            pr = 6'($urandom_range(0, 63));
        return make_cmd(md, 4'($urandom_range(0, 15)), pr, $urandom_range(0, 99) < 90);
    endfunction

    // Gap before the next word: mostly short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gap_stretch) return 0;
        if (r < 5) return $urandom_range(20, 60);
        if (r < 40) return $urandom_range(1, 3);
        return 0;
    endfunction

    // Driver: present words from the queue; enable writes wait for quiet.
    always @(posedge clk)
    begin
        logic nxt_start, nxt_cfg;
        sched_word_t w;
        nxt_start = start;
        nxt_cfg = cfg_valid;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_results.push_back(schedule_command(word_queue.pop_front()));
                nxt_start = 1'b0;
                drv_active = 0;
                accept_count++;
                if (accept_count % 50 == 0)
                    no_gap_stretch = ($urandom_range(0, 2) == 0);
                gap_left = pick_gap();
            end
            if (cfg_valid && cfg_ready)
            begin
                w = word_queue.pop_front();
                m_enable = w.cfg_val;
                nxt_cfg = 1'b0;
                drv_active = 0;
                gap_left = pick_gap();
            end
            if (!drv_active && word_queue.size() > 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                else
                begin
                    w = word_queue[0];
                    if (!w.is_cfg)
                    begin
                        mode <= w.mode;
                        task_id <= w.id;
                        priority_req <= w.prio;
                        stack_intact <= w.intact;
                        nxt_start = 1'b1;
                        drv_active = 1;
                    end
                    else if (expected_results.size() == 0 && idle_cycles >= SettleCyc)
                    begin
                        cfg_data <= w.cfg_val;
                        nxt_cfg = 1'b1;
                        drv_active = 1;
                    end
                end
            end
        end
        start <= nxt_start;
        cfg_valid <= nxt_cfg;
    end

    // Monitor: check each result word against the oldest expectation.
    always @(posedge clk)
    begin
        sched_result_t e;
        if (rst_n)
        begin
            if (done || busy || start)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result word status=%0d current=%0d",
                             $realtime, status, current_id);
                    error_count++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (status !== e.status || created_id !== e.created ||
                        current_id !== e.current || chosen_id !== e.chosen ||
                        busy_percent !== e.busy_pct || floor_runtime !== e.floor_rt)
                    begin
                        $display("%0t: mismatch expected st=%0d cr=%0d cur=%0d ch=%0d bp=%0d fl=%0h",
                                 $realtime, e.status, e.created, e.current, e.chosen,
                                 e.busy_pct, e.floor_rt);
                        $display("%0t:          actual   st=%0d cr=%0d cur=%0d ch=%0d bp=%0d fl=%0h",
                                 $realtime, status, created_id, current_id, chosen_id,
                                 busy_percent, floor_runtime);
                        error_count++;
                    end
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        model_reset();
        // Directed part: disabled tick, table fill, idle-task rules, bad codes.
        word_queue.push_back(make_cmd(MODE_TICK, 4'd0, 6'd0, 1'b0));
        word_queue.push_back(make_cfg(1'b1));
        for (int i = 0; i < 16; i++)
            word_queue.push_back(make_cmd(MODE_CREATE, 4'd15, 6'h3f, 1'b1));
        word_queue.push_back(make_cmd(MODE_DELETE, 4'd0, 6'd0, 1'b1));
        word_queue.push_back(make_cmd(MODE_SUSPEND, 4'd0, 6'd0, 1'b1));
        word_queue.push_back(make_cmd(MODE_TICK, 4'd0, 6'd0, 1'b0));
        word_queue.push_back(make_cmd(MODE_TICK, 4'd0, 6'd0, 1'b0));
        word_queue.push_back(make_cmd(MODE_SETPRIO, 4'd0, 6'(-21), 1'b1));
        word_queue.push_back(make_cmd(MODE_SETPRIO, 4'd0, 6'(-20), 1'b1));
        word_queue.push_back(make_cmd(MODE_SETPRIO, 4'd0, 6'd19, 1'b1));
        word_queue.push_back(make_cmd(MODE_SETPRIO, 4'd0, 6'd20, 1'b1));
        word_queue.push_back(make_cmd(MODE_SUSPEND, 4'd15, 6'd0, 1'b1));
        word_queue.push_back(make_cmd(MODE_SUSPEND, 4'd15, 6'd0, 1'b1));
        word_queue.push_back(make_cmd(MODE_DELETE, 4'd14, 6'd0, 1'b1));
        word_queue.push_back(make_cmd(MODE_DELETE, 4'd14, 6'd0, 1'b1));
        word_queue.push_back(make_cmd(MODE_RESUME, 4'd15, 6'd0, 1'b1));
        word_queue.push_back(make_cmd(MODE_RESUME, 4'd14, 6'd0, 1'b1));
        word_queue.push_back(make_cmd(3'd6, 4'd0, 6'd0, 1'b1));
        word_queue.push_back(make_cmd(3'd7, 4'hf, 6'h3f, 1'b0));
        // Random part in phases separated by enable writes.
        for (int i = 0; i < 450; i++)
        begin
            if (i % 60 == 59)
                word_queue.push_back(make_cfg($urandom_range(0, 3) != 0));
            else if (i % 60 == 0)
                word_queue.push_back(make_cfg(1'b1));
            word_queue.push_back(random_cmd());
        end
        word_queue.push_back(make_cfg(1'b0));
        word_queue.push_back(make_cmd(MODE_TICK, 4'd0, 6'd0, 1'b1));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        do
            @(posedge clk);
        while (word_queue.size() > 0 || drv_active || expected_results.size() > 0);
        repeat (SettleCyc) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
